// ===== rtl/ihp_pkg.sv =====
// Package for the indexed max-heap: field widths, default sizes,
// operation and status codes. No dependencies.
package ihp_pkg;

    localparam int HANDLE_BITS     = 10;
    localparam int HANDLE_SPACE    = 1024;
    localparam int OP_BITS         = 3;
    localparam int STATUS_BITS     = 3;
    localparam int IO_WEIGHT_BITS  = 16;
    localparam int COUNT_OUT_BITS  = 11;

    localparam int CAPACITY_DEF    = 1024;
    localparam int WEIGHT_BITS_DEF = 16;

    localparam logic [OP_BITS-1:0] OP_INSERT = 3'd0;
    localparam logic [OP_BITS-1:0] OP_POP    = 3'd1;
    localparam logic [OP_BITS-1:0] OP_REMOVE = 3'd2;
    localparam logic [OP_BITS-1:0] OP_ADD    = 3'd3;
    localparam logic [OP_BITS-1:0] OP_CLEAR  = 3'd4;

    localparam logic [STATUS_BITS-1:0] ST_OK      = 3'd0;
    localparam logic [STATUS_BITS-1:0] ST_EMPTY   = 3'd1;
    localparam logic [STATUS_BITS-1:0] ST_FULL    = 3'd2;
    localparam logic [STATUS_BITS-1:0] ST_ABSENT  = 3'd3;
    localparam logic [STATUS_BITS-1:0] ST_PRESENT = 3'd4;

endpackage

// ===== rtl/ihp_if.sv =====
// Request and response channel interfaces of the indexed max-heap.
// Depends on ihp_pkg for field widths.
interface ihp_req_if;
    logic                              valid;
    logic                              ready;
    logic [ihp_pkg::OP_BITS-1:0]        op;
    logic [ihp_pkg::HANDLE_BITS-1:0]    handle;
    logic [ihp_pkg::IO_WEIGHT_BITS-1:0] weight;

    modport source (output valid, op, handle, weight, input ready);
    modport sink   (input valid, op, handle, weight, output ready);
endinterface

interface ihp_rsp_if;
    logic                              valid;
    logic                              ready;
    logic [ihp_pkg::STATUS_BITS-1:0]    status;
    logic [ihp_pkg::HANDLE_BITS-1:0]    item_handle;
    logic [ihp_pkg::IO_WEIGHT_BITS-1:0] item_weight;
    logic                              top_valid;
    logic [ihp_pkg::HANDLE_BITS-1:0]    top_handle;
    logic [ihp_pkg::IO_WEIGHT_BITS-1:0] top_weight;
    logic [ihp_pkg::COUNT_OUT_BITS-1:0] count;

    modport source (output valid, status, item_handle, item_weight, top_valid,
                    top_handle, top_weight, count, input ready);
    modport sink   (input valid, status, item_handle, item_weight, top_valid,
                    top_handle, top_weight, count, output ready);
endinterface

// ===== rtl/indexed_max_heap.sv =====
// Indexed max-heap: after the request transfer the FSM steps through S_LOOKUP, S_FETCH,
// the sift-up and sift-down states, S_TOP and S_FIN, where the response is registered.
// Sift-up climbs levels and sift-down descends them; a rejected op or a clear skips both.
// One item at a time; a new request is taken while the previous response still waits,
// and a stalled response holds the following one in S_FIN. Reset empties the heap, then
// clears all 1024 entries of the position map with ready low.
module indexed_max_heap #(
    parameter int CAPACITY    = ihp_pkg::CAPACITY_DEF,
    parameter int WEIGHT_BITS = ihp_pkg::WEIGHT_BITS_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    ihp_req_if.sink   i_req,
    ihp_rsp_if.source o_rsp
);

    localparam int SLOT_W  = $clog2(CAPACITY);
    localparam int CNT_W   = $clog2(CAPACITY + 1);
    localparam int IDX2_W  = SLOT_W + 1;

    typedef struct packed {
        logic [ihp_pkg::HANDLE_BITS-1:0] handle;
        logic [WEIGHT_BITS-1:0]          weight;
    } t_entry;

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_LOOKUP, S_FETCH, S_SU_RD, S_SU_CMP,
        S_SD_RD, S_SD_SEL, S_SD_CMP, S_TOP, S_FIN
    } t_state;

    t_state                              r_state;
    logic [ihp_pkg::HANDLE_BITS-1:0]     r_clr_idx;
    logic [ihp_pkg::OP_BITS-1:0]         r_op;
    logic [ihp_pkg::HANDLE_BITS-1:0]     r_handle;
    logic [ihp_pkg::IO_WEIGHT_BITS-1:0]  r_wt;
    logic [CNT_W-1:0]                    r_count;
    logic [SLOT_W-1:0]                   r_idx;
    logic [SLOT_W-1:0]                   r_par;
    logic [IDX2_W-1:0]                   r_child;
    logic [SLOT_W-1:0]                   r_best_idx;
    t_entry                              r_best;
    t_entry                              r_cur;
    t_entry                              r_item;
    logic                                r_item_ok;
    logic [ihp_pkg::STATUS_BITS-1:0]     r_status;

    logic [SLOT_W-1:0]                   r_pos_q;
    t_entry                              r_rd_a;
    t_entry                              r_rd_b;

    logic                                r_o_valid;
    logic [ihp_pkg::STATUS_BITS-1:0]     r_o_status;
    logic [ihp_pkg::HANDLE_BITS-1:0]     r_o_item_handle;
    logic [ihp_pkg::IO_WEIGHT_BITS-1:0]  r_o_item_weight;
    logic                                r_o_top_valid;
    logic [ihp_pkg::HANDLE_BITS-1:0]     r_o_top_handle;
    logic [ihp_pkg::IO_WEIGHT_BITS-1:0]  r_o_top_weight;
    logic [ihp_pkg::COUNT_OUT_BITS-1:0]  r_o_count;

    t_entry                              heap_mem [CAPACITY];
    logic [SLOT_W-1:0]                   pos_mem  [ihp_pkg::HANDLE_SPACE];

    logic                                req_xfer;
    logic                                ha_en;
    logic [SLOT_W-1:0]                   ha_addr;
    logic                                hb_en;
    logic [SLOT_W-1:0]                   hb_addr;
    logic                                hw_en;
    logic [SLOT_W-1:0]                   hw_addr;
    t_entry                              hw_data;
    logic                                pw_en;
    logic [ihp_pkg::HANDLE_BITS-1:0]     pw_addr;
    logic [SLOT_W-1:0]                   pw_data;
    t_entry                              cmp_x;
    t_entry                              cmp_y;
    logic                                ranks_above;
    logic [WEIGHT_BITS-1:0]              sum_base;
    logic [WEIGHT_BITS-1:0]              sum;
    logic [SLOT_W-1:0]                   last_slot;
    logic [IDX2_W-1:0]                   child;
    logic                                child_out;
    logic [IDX2_W-1:0]                   child_nxt;
    logic                                present;

    assign req_xfer    = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == S_IDLE);

    assign last_slot = SLOT_W'(r_count - 1'b1);
    assign child     = {r_idx, 1'b1};
    assign child_out = (child >= IDX2_W'(r_count));
    assign child_nxt = r_child + 1'b1;
    assign present   = (IDX2_W'(r_idx) < IDX2_W'(r_count)) && (r_rd_a.handle == r_handle);
    assign sum_base  = (r_op == ihp_pkg::OP_ADD) ? r_rd_a.weight : '0;

    ihp_alu #(
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_alu (
        .i_x      (cmp_x),
        .i_y      (cmp_y),
        .i_base   (sum_base),
        .i_delta  (r_wt),
        .o_before (ranks_above),
        .o_sum    (sum)
    );

    always_comb begin
        ha_en   = 1'b0;
        ha_addr = '0;
        hb_en   = 1'b0;
        hb_addr = '0;
        hw_en   = 1'b0;
        hw_addr = r_idx;
        hw_data = r_cur;
        pw_en   = 1'b0;
        pw_addr = r_cur.handle;
        pw_data = r_idx;
        cmp_x   = r_cur;
        cmp_y   = r_rd_a;
        unique case (r_state)
            S_CLR: begin
                pw_en   = 1'b1;
                pw_addr = r_clr_idx;
                pw_data = '0;
            end
            S_LOOKUP: begin
                ha_en   = 1'b1;
                ha_addr = (r_op == ihp_pkg::OP_POP) ? '0 : r_pos_q;
                hb_en   = 1'b1;
                hb_addr = last_slot;
            end
            S_SU_RD: begin
                ha_en   = (r_idx != '0);
                ha_addr = SLOT_W'((r_idx - 1'b1) >> 1);
            end
            S_SU_CMP: begin
                // move parent down into the hole
                if (ranks_above) begin
                    hw_en   = 1'b1;
                    hw_data = r_rd_a;
                    pw_en   = 1'b1;
                    pw_addr = r_rd_a.handle;
                end
            end
            S_SD_RD: begin
                if (child_out) begin
                    hw_en = 1'b1;
                    pw_en = 1'b1;
                end else begin
                    ha_en   = 1'b1;
                    ha_addr = child[SLOT_W-1:0];
                    hb_en   = 1'b1;
                    hb_addr = SLOT_W'(child + 1'b1);
                end
            end
            S_SD_SEL: begin
                cmp_x = r_rd_b;
                cmp_y = r_rd_a;
            end
            S_SD_CMP: begin
                cmp_x = r_best;
                cmp_y = r_cur;
                hw_en = 1'b1;
                pw_en = 1'b1;
                if (ranks_above) begin
                    hw_data = r_best;
                    pw_addr = r_best.handle;
                end
            end
            S_TOP: begin
                ha_en = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (hw_en) begin
            heap_mem[hw_addr] <= hw_data;
        end
        if (ha_en) begin
            r_rd_a <= heap_mem[ha_addr];
        end
        if (hb_en) begin
            r_rd_b <= heap_mem[hb_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (pw_en) begin
            pos_mem[pw_addr] <= pw_data;
        end
        if (req_xfer) begin
            r_pos_q <= pos_mem[i_req.handle];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLR;
            r_clr_idx <= '0;
            r_count   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (r_o_valid && o_rsp.ready && (r_state != S_FIN)) begin
                r_o_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLR: begin
                    r_clr_idx <= r_clr_idx + 1'b1;
                    if (r_clr_idx == '1) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (req_xfer) begin
                        r_op      <= i_req.op;
                        r_handle  <= i_req.handle;
                        r_wt      <= i_req.weight;
                        r_item_ok <= 1'b0;
                        r_status  <= ihp_pkg::ST_OK;
                        r_state   <= S_LOOKUP;
                    end
                end
                S_LOOKUP: begin
                    r_idx   <= ha_addr;
                    r_state <= S_FETCH;
                end
                S_FETCH: begin
                    r_state <= S_TOP;
                    unique case (r_op)
                        ihp_pkg::OP_INSERT: begin
                            if (present) begin
                                r_status <= ihp_pkg::ST_PRESENT;
                            end else if (r_count == CNT_W'(CAPACITY)) begin
                                r_status <= ihp_pkg::ST_FULL;
                            end else begin
                                r_cur   <= '{handle: r_handle, weight: sum};
                                r_idx   <= SLOT_W'(r_count);
                                r_count <= r_count + 1'b1;
                                r_state <= S_SU_RD;
                            end
                        end
                        ihp_pkg::OP_POP: begin
                            if (r_count == '0) begin
                                r_status <= ihp_pkg::ST_EMPTY;
                            end else begin
                                r_item_ok <= 1'b1;
                                r_item    <= r_rd_a;
                                r_count   <= r_count - 1'b1;
                                if (r_idx != last_slot) begin
                                    r_cur   <= r_rd_b;
                                    r_state <= S_SU_RD;
                                end
                            end
                        end
                        ihp_pkg::OP_REMOVE: begin
                            if (!present) begin
                                r_status <= ihp_pkg::ST_ABSENT;
                            end else begin
                                r_item_ok <= 1'b1;
                                r_item    <= r_rd_a;
                                r_count   <= r_count - 1'b1;
                                if (r_idx != last_slot) begin
                                    r_cur   <= r_rd_b;
                                    r_state <= S_SU_RD;
                                end
                            end
                        end
                        ihp_pkg::OP_ADD: begin
                            if (!present) begin
                                r_status <= ihp_pkg::ST_ABSENT;
                            end else begin
                                r_cur   <= '{handle: r_handle, weight: sum};
                                r_state <= S_SU_RD;
                            end
                        end
                        ihp_pkg::OP_CLEAR: begin
                            r_count <= '0;
                        end
                        default: begin
                        end
                    endcase
                end
                S_SU_RD: begin
                    r_par   <= ha_addr;
                    r_state <= (r_idx == '0) ? S_SD_RD : S_SU_CMP;
                end
                S_SU_CMP: begin
                    if (ranks_above) begin
                        r_idx   <= r_par;
                        r_state <= S_SU_RD;
                    end else begin
                        r_state <= S_SD_RD;
                    end
                end
                S_SD_RD: begin
                    r_child <= child;
                    r_state <= child_out ? S_TOP : S_SD_SEL;
                end
                S_SD_SEL: begin
                    if ((child_nxt < IDX2_W'(r_count)) && ranks_above) begin
                        r_best     <= r_rd_b;
                        r_best_idx <= SLOT_W'(child_nxt);
                    end else begin
                        r_best     <= r_rd_a;
                        r_best_idx <= r_child[SLOT_W-1:0];
                    end
                    r_state <= S_SD_CMP;
                end
                S_SD_CMP: begin
                    if (ranks_above) begin
                        r_idx   <= r_best_idx;
                        r_state <= S_SD_RD;
                    end else begin
                        r_state <= S_TOP;
                    end
                end
                S_TOP: begin
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    // hold until the response register is free
                    if (!r_o_valid || o_rsp.ready) begin
                        r_o_valid       <= 1'b1;
                        r_o_status      <= r_status;
                        r_o_item_handle <= r_item_ok ? r_item.handle : '0;
                        r_o_item_weight <= r_item_ok ?
                                           ihp_pkg::IO_WEIGHT_BITS'(r_item.weight) : '0;
                        r_o_top_valid   <= (r_count != '0);
                        r_o_top_handle  <= (r_count != '0) ? r_rd_a.handle : '0;
                        r_o_top_weight  <= (r_count != '0) ?
                                           ihp_pkg::IO_WEIGHT_BITS'(r_rd_a.weight) : '0;
                        r_o_count       <= ihp_pkg::COUNT_OUT_BITS'(r_count);
                        r_state         <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_rsp.valid       = r_o_valid;
    assign o_rsp.status      = r_o_status;
    assign o_rsp.item_handle = r_o_item_handle;
    assign o_rsp.item_weight = r_o_item_weight;
    assign o_rsp.top_valid   = r_o_top_valid;
    assign o_rsp.top_handle  = r_o_top_handle;
    assign o_rsp.top_weight  = r_o_top_weight;
    assign o_rsp.count       = r_o_count;

    a_write_in_heap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        hw_en |-> (IDX2_W'(hw_addr) < IDX2_W'(r_count)))
        else $error("heap write outside the held entries");

    a_child_in_heap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SD_SEL) |-> (r_child < IDX2_W'(r_count)))
        else $error("sift-down child beyond the held entries");

    a_insert_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FETCH && r_op == ihp_pkg::OP_INSERT) |=>
        (r_count == $past(r_count)) || (r_count == $past(r_count) + 1'b1))
        else $error("insert changed the count by more than one");

    a_accept_lookup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_xfer |=> (r_state == S_LOOKUP))
        else $error("accepted request did not start a lookup");

    a_ws_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && r_o_valid && !o_rsp.ready) |=> (r_state == S_FIN))
        else $error("response dropped while the output was stalled");

endmodule

// ===== rtl/ihp_alu.sv =====
// Shared heap unit: priority compare of two entries and saturating
// weight add. Depends on ihp_pkg.
module ihp_alu #(
    parameter int WEIGHT_BITS = ihp_pkg::WEIGHT_BITS_DEF
) (
    input  logic [ihp_pkg::HANDLE_BITS+WEIGHT_BITS-1:0] i_x,
    input  logic [ihp_pkg::HANDLE_BITS+WEIGHT_BITS-1:0] i_y,
    input  logic [WEIGHT_BITS-1:0]                      i_base,
    input  logic [ihp_pkg::IO_WEIGHT_BITS-1:0]          i_delta,
    output logic                                        o_before,
    output logic [WEIGHT_BITS-1:0]                      o_sum
);

    localparam int SUM_W = ((WEIGHT_BITS > ihp_pkg::IO_WEIGHT_BITS) ?
                            WEIGHT_BITS : ihp_pkg::IO_WEIGHT_BITS) + 1;
    localparam logic [SUM_W-1:0] WMAX = {{(SUM_W-WEIGHT_BITS){1'b0}}, {WEIGHT_BITS{1'b1}}};

    typedef struct packed {
        logic [ihp_pkg::HANDLE_BITS-1:0] handle;
        logic [WEIGHT_BITS-1:0]          weight;
    } t_entry;

    t_entry             x;
    t_entry             y;
    logic [SUM_W-1:0]   sum;

    assign x = i_x;
    assign y = i_y;

    // x ranks above y: higher weight, then smaller handle
    assign o_before = (x.weight != y.weight) ? (x.weight > y.weight)
                                             : (x.handle < y.handle);

    assign sum   = SUM_W'(i_base) + SUM_W'(i_delta);
    assign o_sum = (sum > WMAX) ? WMAX[WEIGHT_BITS-1:0] : sum[WEIGHT_BITS-1:0];

endmodule
